// ===== hdl/ilir_pkg.sv =====
// Shared types and constants for the indexed list block.
// Used by ilir_ctrl and indexed_list_insert_remove_top; no dependencies.
package ilir_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4,
    MODE_CLEAR  = 3'd5
  } ilir_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } ilir_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_UP,
    ST_PUT,
    ST_DOWN,
    ST_DONE
  } ilir_state_e;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    ilir_status_e      status;
    logic [CNT_W-1:0]  count;
  } ilir_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ilir_mem_req_t;

endpackage

// ===== hdl/ilir_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
module ilir_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/ilir_ctrl.sv =====
// Sequencer for the indexed list: decodes one request, then walks the entry
// memory one address per cycle to shift entries. Depends on ilir_pkg.
module ilir_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ilir_pkg::ilir_mode_e              in_mode_i,
  input  logic [ilir_pkg::POS_W-1:0]        in_pos_i,
  input  logic [ilir_pkg::WORD_W-1:0]       in_val_i,
  input  logic [ilir_pkg::CNT_W-1:0]        cap_i,
  input  logic [ilir_pkg::WORD_W-1:0]       mem_rdata_i,
  output ilir_pkg::ilir_mem_req_t           mem_req_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output ilir_pkg::ilir_res_t               res_o
);
  import ilir_pkg::*;

  ilir_state_e       state_q, state_d;
  ilir_mode_e        mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  logic [WORD_W-1:0] res_q, res_d;
  ilir_status_e      status_q, status_d;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] addr_inc;
  logic [ADDR_W-1:0] addr_dec;
  logic              full;
  logic              empty;
  logic              pos_le;
  logic              pos_lt;
  logic              at_pos;
  logic              at_last;

  // Shared address stepper and compares used by every sequence.
  assign limit     = (cap_i < CNT_W'(DEPTH)) ? cap_i : CNT_W'(DEPTH);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign last_addr = cnt_m1[ADDR_W-1:0];
  assign pos_addr  = pos_q[ADDR_W-1:0];
  assign addr_inc  = paddr_q + ADDR_W'(1);
  assign addr_dec  = paddr_q - ADDR_W'(1);
  assign full      = count_q >= limit;
  assign empty     = count_q == '0;
  assign pos_le    = pos_q <= count_q;
  assign pos_lt    = pos_q < count_q;
  assign at_pos    = paddr_q == pos_addr;
  assign at_last   = paddr_q == last_addr;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (mode_q)
          MODE_INSERT: begin
            if (!full && pos_le && (pos_q != count_q)) state_d = ST_UP;
          end
          MODE_POP: begin
            if (!empty) state_d = ST_DOWN;
          end
          MODE_REMOVE, MODE_READ: begin
            if (pos_lt) state_d = ST_DOWN;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_UP: begin
        if (at_pos) state_d = ST_PUT;
      end
      ST_PUT:  state_d = ST_DONE;
      ST_DOWN: begin
        if (mode_q != MODE_REMOVE || at_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_d          = mode_q;
    pos_d           = pos_q;
    val_d           = val_q;
    count_d         = count_q;
    paddr_d         = paddr_q;
    res_d           = res_q;
    status_d        = status_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = paddr_q;
    mem_req_o.wdata = val_q;
    mem_req_o.raddr = paddr_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d   = in_mode_i;
          pos_d    = in_pos_i;
          val_d    = in_val_i;
          res_d    = '0;
          status_d = STATUS_OK;
        end
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_APPEND: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = count_q[ADDR_W-1:0];
              count_d         = count_q + CNT_W'(1);
            end
          end
          MODE_INSERT: begin
            if (full) begin
              status_d = STATUS_FULL;
            end else if (!pos_le) begin
              status_d = STATUS_RANGE;
            end else if (pos_q == count_q) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = pos_addr;
              count_d         = count_q + CNT_W'(1);
            end else begin
              mem_req_o.raddr = last_addr;
              paddr_d         = last_addr;
            end
          end
          MODE_POP: begin
            if (empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              mem_req_o.raddr = last_addr;
              paddr_d         = last_addr;
            end
          end
          MODE_REMOVE: begin
            if (empty) begin
              status_d = STATUS_EMPTY;
            end else if (!pos_lt) begin
              status_d = STATUS_RANGE;
            end else begin
              mem_req_o.raddr = pos_addr;
              paddr_d         = pos_addr;
            end
          end
          MODE_READ: begin
            if (!pos_lt) begin
              status_d = STATUS_RANGE;
            end else begin
              mem_req_o.raddr = pos_addr;
              paddr_d         = pos_addr;
            end
          end
          MODE_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      ST_UP: begin
        // The word read last cycle moves one place up while the next is read.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = addr_inc;
        mem_req_o.wdata = mem_rdata_i;
        if (!at_pos) begin
          mem_req_o.raddr = addr_dec;
          paddr_d         = addr_dec;
        end
      end
      ST_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_addr;
        count_d         = count_q + CNT_W'(1);
      end
      ST_DOWN: begin
        if (mode_q == MODE_REMOVE) begin
          if (at_pos) begin
            res_d = mem_rdata_i;
          end else begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = addr_dec;
            mem_req_o.wdata = mem_rdata_i;
          end
          if (at_last) begin
            count_d = cnt_m1;
          end else begin
            mem_req_o.raddr = addr_inc;
            paddr_d         = addr_inc;
          end
        end else begin
          res_d = mem_rdata_i;
          if (mode_q == MODE_POP) count_d = cnt_m1;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o   = state_q == ST_IDLE;
  assign res_valid_o  = state_q == ST_DONE;
  assign res_o.value  = res_q;
  assign res_o.status = status_q;
  assign res_o.count  = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    paddr_q  <= paddr_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1) ||
       count_q == '0))
    else $error("entry count moved by more than one");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !mem_req_o.we)
    else $error("memory written outside an operation");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted beat not decoded");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_q != STATUS_OK) |-> (res_q == '0))
    else $error("rejected operation returned data");

endmodule

// ===== hdl/indexed_list_insert_remove_top.sv =====
// Top level of the indexed list: request and result streams, capacity register.
// Depends on ilir_pkg, ilir_ram and ilir_ctrl.
//
// Requests arrive as beats on the s_axis channel, results leave on m_axis, one
// result beat per request. The capacity register is written through cfg_*.
// Entries live in a 64-word memory with one write and one read port; the
// sequencer moves one entry per cycle while shifting.
// Each request is decoded, then finished at once for append, clear, insert
// at the end and rejected requests; pop and read first fetch one entry,
// remove shifts the entries above the position down one place, and insert
// before the end shifts entries up from the last to the position, then writes.
// The next request can be accepted in the cycle after the result is loaded.
// A new request is accepted while the previous result waits in the output
// register; if the receiver stalls, the sequencer holds its finished result
// and accepts nothing further until the output register frees up.
// Reset empties the list and sets the capacity to 64; memory contents are
// not cleared, since only written entries are ever read.
module indexed_list_insert_remove_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [39:0]                        s_axis_tdata,  // position[6:0], value[38:7]
  input  logic [ilir_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[2:0]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // result_value[31:0], entry_count[38:32]
  output logic [ilir_pkg::STATUS_W-1:0]      m_axis_tuser,  // status[1:0]
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ilir_pkg::CNT_W-1:0]         cfg_data_i
);
  import ilir_pkg::*;

  logic [CNT_W-1:0] cap_q;
  logic             out_valid_q;
  ilir_res_t        out_q;
  ilir_res_t        res;
  logic             res_valid;
  logic             res_ready;
  ilir_mem_req_t    mem_req;
  logic [WORD_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  ilir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (ilir_mode_e'(s_axis_tuser)),
    .in_pos_i    (s_axis_tdata[POS_W-1:0]),
    .in_val_i    (s_axis_tdata[POS_W+WORD_W-1:POS_W]),
    .cap_i       (cap_q),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ilir_ram #(
    .Depth (DEPTH),
    .Width (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.count, out_q.value};
  assign m_axis_tuser  = out_q.status;

endmodule
